FILE: design/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is high.
`define SLFR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked during reset too.
`define SLFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/slfr_pkg.sv
// Types and constants of the serial line frame receiver.
package slfr_pkg;

   localparam int BUF_DEPTH_DEFAULT = 256;

   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_OPEN  = 8'h3c;
   localparam logic [7:0] CHAR_CLOSE = 8'h3e;

   localparam logic MODE_LINE    = 1'b0;
   localparam logic MODE_BRACKET = 1'b1;

   typedef enum logic [1:0] {
      ACT_RX_BYTE = 2'd0,
      ACT_CLEAR   = 2'd1,
      ACT_READ    = 2'd2,
      ACT_NOP     = 2'd3
   } action_type;

   // Status after one item, plus the buffer write request it causes.
   typedef struct packed {
      logic wr_en;
      logic done;
      logic marker;
      logic restarted;
   } step_type;

endpackage

FILE: design/serial_line_frame_receiver_unit.sv
// Top level of the serial line frame receiver.
//
// Usage:
//   req_ channel carries one item per accepted cycle: action, rx_byte and
//   read_index. Action 0 feeds a received byte to the framer, 1 clears the
//   receiver status, 2 reads one buffer byte, 3 only reports the status.
//   rsp_ channel returns exactly one result per item: frame_done,
//   marker_seen, byte_count, restarted and read_data.
//   csr_ channel writes framing_mode (0 = CR LF line, 1 = '<' ... '>').
//   csr_ready is always high; write it only while no item is in flight.
// Timing:
//   Each result appears in the cycle after acceptance, and a new item is
//   taken every cycle unless stalled. The frame buffer is one RAM with a
//   write port for received bytes and a registered read port for reads;
//   both work at the accept edge, so a read sees all earlier writes.
// Reset clears the status, the mode and rsp_valid; result data and buffer
//   contents stay undefined until written. When rsp_stall is high with a
//   result waiting, req_stall rises and the result and RAM output hold.
module serial_line_frame_receiver_unit #(
   parameter int BUF_DEPTH = slfr_pkg::BUF_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_action,
   input  logic [7:0] req_rx_byte,
   input  logic [7:0] req_read_index,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_frame_done,
   output logic       rsp_marker_seen,
   output logic [8:0] rsp_byte_count,
   output logic       rsp_restarted,
   output logic [7:0] rsp_read_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_framing_mode
);

   localparam int AW  = $clog2(BUF_DEPTH);
   localparam int CW  = $clog2(BUF_DEPTH + 1);
   localparam int XW  = (AW > 8) ? AW : 8;
   localparam int BCW = (CW > 9) ? CW : 9;

   slfr_pkg::step_type step;
   logic [CW-1:0]      count_next;
   logic [BCW-1:0]     count_wide;
   logic [AW-1:0]      wr_addr;
   logic               accept;
   logic               is_read;
   logic [XW-1:0]      idx_x;
   logic               idx_ok;
   logic [7:0]         ram_rd_data;

   logic               rsp_valid_ff;
   logic               done_ff;
   logic               marker_ff;
   logic [8:0]         count_ff;
   logic               restarted_ff;
   logic               is_read_ff;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign idx_x   = XW'(req_read_index);
   assign idx_ok  = ({1'b0, idx_x} < (XW + 1)'(BUF_DEPTH));
   assign is_read = (slfr_pkg::action_type'(req_action) == slfr_pkg::ACT_READ) && idx_ok;

   slfr_ctrl #(
      .BUF_DEPTH(BUF_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .action    (req_action),
      .rx_byte   (req_rx_byte),
      .csr_we    (csr_valid && csr_ready),
      .csr_mode  (csr_framing_mode),
      .step      (step),
      .count_next(count_next),
      .wr_addr   (wr_addr)
   );

   slfr_ram #(
      .WIDTH(8),
      .DEPTH(BUF_DEPTH)
   ) u_buf (
      .clock  (clock),
      .wr_en  (step.wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_rx_byte),
      .rd_en  (accept && is_read),
      .rd_addr(idx_x[AW-1:0]),
      .rd_data(ram_rd_data)
   );

   assign count_wide = BCW'(count_next);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         rsp_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         done_ff      <= step.done;
         marker_ff    <= step.marker;
         count_ff     <= count_wide[8:0];
         restarted_ff <= step.restarted;
         is_read_ff   <= is_read;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_done  = done_ff;
   assign rsp_marker_seen = marker_ff;
   assign rsp_byte_count  = count_ff;
   assign rsp_restarted   = restarted_ff;
   assign rsp_read_data   = is_read_ff ? ram_rd_data : 8'd0;

endmodule

FILE: design/slfr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module slfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/slfr_ctrl.sv
// Receiver status registers and the per-item framing update.
module slfr_ctrl #(
   parameter int BUF_DEPTH = slfr_pkg::BUF_DEPTH_DEFAULT,
   localparam int AW = $clog2(BUF_DEPTH),
   localparam int CW = $clog2(BUF_DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [1:0]         action,
   input  logic [7:0]         rx_byte,
   input  logic               csr_we,
   input  logic               csr_mode,
   output slfr_pkg::step_type step,
   output logic [CW-1:0]      count_next,
   output logic [AW-1:0]      wr_addr
);

   logic          mode_ff;
   logic [CW-1:0] count_ff, count_in;
   logic          marker_ff, marker_in;
   logic          done_ff, done_in;
   logic          restart;
   logic          wr_en;
   logic [CW-1:0] base_cnt;
   logic [CW-1:0] inc_cnt;
   logic          is_open;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= slfr_pkg::MODE_LINE;
         count_ff  <= '0;
         marker_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            mode_ff <= csr_mode;
         end
         count_ff  <= count_in;
         marker_ff <= marker_in;
         done_ff   <= done_in;
      end
   end

   // '<' in bracket mode restarts the frame and is stored at slot 0
   assign is_open  = (mode_ff == slfr_pkg::MODE_BRACKET) && (rx_byte == slfr_pkg::CHAR_OPEN);
   assign base_cnt = is_open ? '0 : count_ff;
   assign inc_cnt  = base_cnt + 1'b1;
   assign wr_addr  = (base_cnt == CW'(BUF_DEPTH)) ? '0 : base_cnt[AW-1:0];

   always_comb begin
      count_in  = count_ff;
      marker_in = marker_ff;
      done_in   = done_ff;
      restart   = 1'b0;
      wr_en     = 1'b0;
      if (accept) begin
         case (slfr_pkg::action_type'(action))
            slfr_pkg::ACT_RX_BYTE: begin
               if (mode_ff == slfr_pkg::MODE_LINE) begin
                  if (done_ff) begin
                     // frame complete: byte dropped
                  end else if (marker_ff) begin
                     if (rx_byte == slfr_pkg::CHAR_LF) begin
                        done_in = 1'b1;
                     end else begin
                        count_in  = '0;
                        marker_in = 1'b0;
                        restart   = 1'b1;
                     end
                  end else if (rx_byte == slfr_pkg::CHAR_CR) begin
                     marker_in = 1'b1;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = inc_cnt;
                     if (inc_cnt == CW'(BUF_DEPTH)) begin
                        count_in = '0;
                        restart  = 1'b1;
                     end
                  end
               end else begin
                  if (is_open) begin
                     count_in  = '0;
                     marker_in = 1'b1;
                     done_in   = 1'b0;
                  end
                  if (!done_in && marker_in) begin
                     wr_en    = 1'b1;
                     count_in = inc_cnt;
                     if (rx_byte == slfr_pkg::CHAR_CLOSE) begin
                        done_in = 1'b1;
                     end else if (inc_cnt == CW'(BUF_DEPTH)) begin
                        count_in  = '0;
                        marker_in = 1'b0;
                        done_in   = 1'b0;
                        restart   = 1'b1;
                     end
                  end
               end
            end
            slfr_pkg::ACT_CLEAR: begin
               count_in  = '0;
               marker_in = 1'b0;
               done_in   = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   assign step.wr_en     = wr_en;
   assign step.done      = done_in;
   assign step.marker    = marker_in;
   assign step.restarted = restart;
   assign count_next     = count_in;

endmodule

FILE: design/slfr_checker.sv
// Port-level checker for the serial line frame receiver, bound to the top level.
`include "assert_macros.svh"

module slfr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [1:0] req_action,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_frame_done,
   input logic       rsp_marker_seen,
   input logic [8:0] rsp_byte_count,
   input logic       rsp_restarted,
   input logic [7:0] rsp_read_data
);

   `SLFR_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid right after reset")
   `SLFR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_byte_count) && $stable(rsp_read_data), "stalled result changed")
   `SLFR_ASSERT(a_restart_clears, clock, reset, rsp_valid && rsp_restarted |-> !rsp_frame_done && !rsp_marker_seen && rsp_byte_count == 9'd0, "restart left status behind")
   `SLFR_ASSERT(a_done_marked, clock, reset, rsp_valid && rsp_frame_done |-> rsp_marker_seen, "frame done without marker")
   `SLFR_ASSERT(a_read_only, clock, reset, req_valid && !req_stall && req_action != slfr_pkg::ACT_READ |=> rsp_read_data == 8'd0, "read data on a non-read item")

endmodule

bind serial_line_frame_receiver_unit slfr_checker u_slfr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_action     (req_action),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_frame_done (rsp_frame_done),
   .rsp_marker_seen(rsp_marker_seen),
   .rsp_byte_count (rsp_byte_count),
   .rsp_restarted  (rsp_restarted),
   .rsp_read_data  (rsp_read_data)
);

FILE: verif/serial_line_frame_receiver_unit_test.sv
// Self-checking testbench for the serial line frame receiver unit.
module serial_line_frame_receiver_unit_test;

   localparam int DEPTH         = slfr_pkg::BUF_DEPTH_DEFAULT;
   localparam int RANDOM_TARGET = 1000;

   typedef struct {
      slfr_pkg::action_type action;
      logic [7:0]           rx_byte;
      logic [7:0]           read_index;
   } rx_item_type;

   typedef struct {
      logic       done;
      logic       marker;
      logic [8:0] count;
      logic       restarted;
      logic [7:0] data;
   } frame_status_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_action = slfr_pkg::ACT_NOP;
   logic [7:0] req_rx_byte = 8'h00;
   logic [7:0] req_read_index = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_frame_done;
   logic       rsp_marker_seen;
   logic [8:0] rsp_byte_count;
   logic       rsp_restarted;
   logic [7:0] rsp_read_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_framing_mode = slfr_pkg::MODE_LINE;

   serial_line_frame_receiver_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_rx_byte      (req_rx_byte),
      .req_read_index   (req_read_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_marker_seen  (rsp_marker_seen),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_restarted    (rsp_restarted),
      .rsp_read_data    (rsp_read_data),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_framing_mode (csr_framing_mode)
   );

   always #5 clock = ~clock;

   // Receiver state as the testbench sees it
   logic [7:0]       frame_mem [DEPTH];
   bit               mem_written [DEPTH];
   int               written_total = 0;
   int               count_q = 0;
   logic             marker_q = 1'b0;
   logic             done_q = 1'b0;
   logic             framing_q = slfr_pkg::MODE_LINE;

   rx_item_type      rx_backlog [$];
   frame_status_type status_due [$];
   rx_item_type      drv_item;
   frame_status_type rsp_want;
   int               mismatch_count = 0;
   int               result_index = 0;
   int               planned = 0;
   int               req_gap_pct = 37;
   int               rsp_hold_pct = 37;

   function automatic void drop_status();
      count_q  = 0;
      marker_q = 1'b0;
      done_q   = 1'b0;
   endfunction

   function automatic void store_rx(input logic [7:0] b);
      int slot;
      slot = count_q % DEPTH;
      frame_mem[slot] = b;
      if (!mem_written[slot]) begin
         mem_written[slot] = 1'b1;
         written_total++;
      end
      count_q++;
   endfunction

   function automatic logic line_byte_step(input logic [7:0] b);
      if (done_q) return 1'b0;
      if (marker_q) begin
         // anything but LF after CR throws the line away
         if (b != slfr_pkg::CHAR_LF) begin
            drop_status();
            return 1'b1;
         end
         done_q = 1'b1;
         return 1'b0;
      end
      if (b == slfr_pkg::CHAR_CR) begin
         marker_q = 1'b1;
         return 1'b0;
      end
      store_rx(b);
      if (count_q >= DEPTH) begin
         drop_status();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic bracket_byte_step(input logic [7:0] b);
      if (b == slfr_pkg::CHAR_OPEN) begin
         count_q  = 0;
         marker_q = 1'b1;
         done_q   = 1'b0;
      end
      if (done_q || !marker_q) return 1'b0;
      store_rx(b);
      if (b == slfr_pkg::CHAR_CLOSE) begin
         done_q = 1'b1;
         return 1'b0;
      end
      if (count_q >= DEPTH) begin
         drop_status();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Applies one accepted item and queues the status it should produce.
   function automatic void advance_receiver(input rx_item_type it);
      frame_status_type s;
      s.restarted = 1'b0;
      s.data      = 8'h00;
      case (it.action)
         slfr_pkg::ACT_RX_BYTE: begin
            if (framing_q == slfr_pkg::MODE_BRACKET) s.restarted = bracket_byte_step(it.rx_byte);
            else s.restarted = line_byte_step(it.rx_byte);
         end
         slfr_pkg::ACT_CLEAR: drop_status();
         slfr_pkg::ACT_READ: s.data = frame_mem[it.read_index];
         default: ;
      endcase
      s.done   = done_q;
      s.marker = marker_q;
      s.count  = count_q[8:0];
      status_due.push_back(s);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at result %0d: %s", result_index, msg);
      mismatch_count++;
   endtask

   // Driver: one item per accept, random gaps between items
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) advance_receiver(drv_item);
         if (rx_backlog.size() != 0 && $urandom_range(0, 99) >= req_gap_pct) begin
            drv_item = rx_backlog.pop_front();
            req_valid      <= 1'b1;
            req_action     <= drv_item.action;
            req_rx_byte    <= drv_item.rx_byte;
            req_read_index <= drv_item.read_index;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_hold_pct);
   end

   // Monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (status_due.size() == 0) begin
            report_mismatch("result with no item outstanding");
         end else begin
            rsp_want = status_due.pop_front();
            if (rsp_frame_done !== rsp_want.done)
               report_mismatch($sformatf("frame_done %b, want %b",
                                         rsp_frame_done, rsp_want.done));
            if (rsp_marker_seen !== rsp_want.marker)
               report_mismatch($sformatf("marker_seen %b, want %b",
                                         rsp_marker_seen, rsp_want.marker));
            if (rsp_byte_count !== rsp_want.count)
               report_mismatch($sformatf("byte_count %0d, want %0d",
                                         rsp_byte_count, rsp_want.count));
            if (rsp_restarted !== rsp_want.restarted)
               report_mismatch($sformatf("restarted %b, want %b",
                                         rsp_restarted, rsp_want.restarted));
            if (rsp_read_data !== rsp_want.data)
               report_mismatch($sformatf("read_data %h, want %h",
                                         rsp_read_data, rsp_want.data));
         end
         result_index++;
      end
   end

   function automatic void queue_item(input slfr_pkg::action_type a, input logic [7:0] b,
                                      input logic [7:0] idx, input bit counted);
      rx_item_type it;
      it.action     = a;
      it.rx_byte    = b;
      it.read_index = idx;
      rx_backlog.push_back(it);
      if (counted) planned++;
   endfunction

   function automatic void queue_rx(input logic [7:0] b);
      queue_item(slfr_pkg::ACT_RX_BYTE, b, 8'($urandom_range(0, 255)), 1'b1);
   endfunction

   function automatic void queue_op(input slfr_pkg::action_type a);
      queue_item(a, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
   endfunction

   function automatic void queue_read(input logic [7:0] idx);
      queue_item(slfr_pkg::ACT_READ, 8'($urandom_range(0, 255)), idx, 1'b1);
   endfunction

   // A byte that is none of the framing characters
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == slfr_pkg::CHAR_CR || b == slfr_pkg::CHAR_LF ||
             b == slfr_pkg::CHAR_OPEN || b == slfr_pkg::CHAR_CLOSE);
      return b;
   endfunction

   // Reads only target entries written by earlier, fully retired phases.
   function automatic void queue_written_read();
      logic [7:0] idx;
      if (written_total == 0) return;
      do idx = 8'($urandom_range(0, 255));
      while (!mem_written[idx]);
      queue_read(idx);
   endfunction

   function automatic int frame_length();
      if ($urandom_range(0, 24) == 0) return $urandom_range(200, 300);
      return $urandom_range(0, 12);
   endfunction

   function automatic void plan_line_frame();
      int len;
      int roll;
      len = frame_length();
      for (int i = 0; i < len; i++) queue_rx(plain_byte());
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
         queue_rx(slfr_pkg::CHAR_CR);
         queue_rx(slfr_pkg::CHAR_LF);
         if ($urandom_range(0, 4) == 0) begin
            for (int i = $urandom_range(1, 2); i > 0; i--)
               queue_item(slfr_pkg::ACT_RX_BYTE, 8'($urandom_range(0, 255)), 8'h00, 1'b0);
         end
         queue_op(slfr_pkg::ACT_CLEAR);
      end else if (roll < 90) begin
         queue_rx(slfr_pkg::CHAR_CR);
         do queue_rx(8'($urandom_range(0, 255)));
         while (rx_backlog[$].rx_byte == slfr_pkg::CHAR_LF);
      end
   endfunction

   function automatic void plan_bracket_frame();
      int len;
      if ($urandom_range(0, 9) < 3)
         queue_item(slfr_pkg::ACT_RX_BYTE, plain_byte(), 8'h00, 1'b0);
      queue_rx(slfr_pkg::CHAR_OPEN);
      len = frame_length();
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 19) == 0) queue_rx(slfr_pkg::CHAR_OPEN);
         else queue_rx(plain_byte());
      end
      if ($urandom_range(0, 4) != 0) queue_rx(slfr_pkg::CHAR_CLOSE);
      if ($urandom_range(0, 4) == 0)
         queue_item(slfr_pkg::ACT_RX_BYTE, plain_byte(), 8'h00, 1'b0);
   endfunction

   function automatic void plan_random_phase(input int n);
      int start;
      int roll;
      start = planned;
      while (planned - start < n) begin
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            if (framing_q == slfr_pkg::MODE_BRACKET) plan_bracket_frame();
            else plan_line_frame();
         end else if (roll < 82) begin
            for (int i = $urandom_range(1, 3); i > 0; i--) queue_written_read();
         end else begin
            // noise: any action with raw fields
            case ($urandom_range(0, 3))
               0: queue_rx(8'($urandom_range(0, 255)));
               1: queue_op(slfr_pkg::ACT_CLEAR);
               2: queue_written_read();
               default: queue_op(slfr_pkg::ACT_NOP);
            endcase
         end
      end
   endfunction

   task automatic wait_drained();
      @(posedge clock);
      while (rx_backlog.size() != 0 || req_valid || status_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      @(posedge clock);
      csr_valid        <= 1'b1;
      csr_framing_mode <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      framing_q = m;
      csr_valid <= 1'b0;
   endtask

   initial begin
      int phase;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: line mode
      write_mode(slfr_pkg::MODE_LINE);
      queue_op(slfr_pkg::ACT_NOP);
      queue_rx(8'h00);
      queue_rx(8'hff);
      queue_rx(8'h41);
      queue_rx(slfr_pkg::CHAR_CR);
      queue_rx(slfr_pkg::CHAR_LF);
      queue_rx(8'h78);           // ignored while the frame is complete
      queue_op(slfr_pkg::ACT_CLEAR);
      queue_rx(8'h61);
      queue_rx(slfr_pkg::CHAR_CR);
      queue_rx(8'h62);           // bad byte after CR
      queue_rx(slfr_pkg::CHAR_CR);
      queue_rx(slfr_pkg::CHAR_LF);  // empty line
      queue_op(slfr_pkg::ACT_CLEAR);
      wait_drained();

      // directed: bracket mode
      write_mode(slfr_pkg::MODE_BRACKET);
      queue_rx(8'h7a);           // no start mark yet
      queue_rx(slfr_pkg::CHAR_OPEN);
      queue_rx(8'h71);
      queue_rx(slfr_pkg::CHAR_OPEN);   // restart mid-frame
      queue_rx(8'hff);
      queue_rx(slfr_pkg::CHAR_CLOSE);
      queue_rx(8'h79);           // ignored while done
      queue_rx(slfr_pkg::CHAR_OPEN);   // restart from a complete frame
      queue_rx(slfr_pkg::CHAR_CLOSE);
      queue_read(8'd0);
      queue_read(8'd1);
      queue_op(slfr_pkg::ACT_CLEAR);
      wait_drained();
      planned = 0;

      // line overflow on a full buffer, back to back
      req_gap_pct  = 0;
      rsp_hold_pct = 0;
      write_mode(slfr_pkg::MODE_LINE);
      for (int i = 0; i < DEPTH; i++) queue_rx(plain_byte());
      plan_random_phase(40);
      wait_drained();

      // close mark on the last free slot, then bracket overflow
      req_gap_pct  = 37;
      rsp_hold_pct = 37;
      write_mode(slfr_pkg::MODE_BRACKET);
      queue_rx(slfr_pkg::CHAR_OPEN);
      for (int i = 0; i < DEPTH - 2; i++) queue_rx(plain_byte());
      queue_rx(slfr_pkg::CHAR_CLOSE);
      queue_rx(slfr_pkg::CHAR_OPEN);
      for (int i = 0; i < DEPTH - 1; i++) queue_rx(plain_byte());
      plan_random_phase(40);
      wait_drained();

      // mode flips between phases leave frames half done on purpose
      phase = 0;
      while (planned < RANDOM_TARGET) begin
         req_gap_pct  = (phase % 4 == 1) ? 0 : 37;
         rsp_hold_pct = req_gap_pct;
         write_mode($urandom_range(0, 1) ? slfr_pkg::MODE_BRACKET : slfr_pkg::MODE_LINE);
         plan_random_phase($urandom_range(30, 80));
         wait_drained();
         phase++;
      end

      repeat (4) @(posedge clock);
      if (mismatch_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+design
design/slfr_pkg.sv
design/slfr_ram.sv
design/slfr_ctrl.sv
design/serial_line_frame_receiver_unit.sv
design/slfr_checker.sv
verif/serial_line_frame_receiver_unit_test.sv
